FILE: rtl/npf_pkg.sv
// ----------------------------------------------------------------------------
// npf_pkg: shared constants and types for the nth prime finder
// Field widths, range limits and the request/response bundles of the
// shared remainder unit.
// ----------------------------------------------------------------------------
package npf_pkg;

  // Range limits
  localparam int MAX_INDEX   = 4096;
  localparam int PRIME_WIDTH = 16;
  localparam int IDX_W       = 13;

  // Candidate carries one extra bit to see it pass the prime width
  localparam int CAND_W = PRIME_WIDTH + 1;
  // Trial divisors never pass sqrt(2^PRIME_WIDTH), plus one to hold the stop value
  localparam int DIV_W  = PRIME_WIDTH / 2 + 1;
  // Running square of the divisor
  localparam int SQ_W   = 2 * DIV_W - 1;
  // Bit counter of the remainder unit
  localparam int STEP_W = $clog2(PRIME_WIDTH);

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [PRIME_WIDTH-1:0] prime_t;

  // Request into the remainder unit
  typedef struct packed {
    logic                   start;
    logic [PRIME_WIDTH-1:0] dividend;
    logic [DIV_W-1:0]       divisor;
  } rem_req_t;

  // Response out of the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_rsp_t;

endpackage

FILE: rtl/npf_rem_unit.sv
// ----------------------------------------------------------------------------
// npf_rem_unit: shift-subtract remainder unit
// Computes dividend mod divisor one dividend bit per cycle and reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module npf_rem_unit (
  input  logic              clk,
  input  logic              rst,
  input  npf_pkg::rem_req_t req,
  output npf_pkg::rem_rsp_t rsp
);
  import npf_pkg::*;

  logic                   running;
  logic [STEP_W-1:0]      step;
  logic [PRIME_WIDTH-1:0] dvd;
  logic [DIV_W-1:0]       dsr;
  logic [DIV_W-1:0]       rem;
  logic [DIV_W-1:0]       rem_next;
  logic [DIV_W:0]         rem_sh;
  logic                   done;
  logic                   rem_zero;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    rem_sh = {rem, dvd[PRIME_WIDTH-1]};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = DIV_W'(rem_sh - {1'b0, dsr});
    end else begin
      rem_next = rem_sh[DIV_W-1:0];
    end
  end

  // Control: run for one pass over the dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(PRIME_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[PRIME_WIDTH-2:0], 1'b0};
      rem <= rem_next;
      if (step == STEP_W'(PRIME_WIDTH - 1)) begin
        rem_zero <= (rem_next == '0);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.rem_zero = rem_zero;

endmodule

FILE: rtl/nth_prime_finder.sv
// ----------------------------------------------------------------------------
// nth_prime_finder: returns the nth prime by trial division
// Sequencer that walks candidates upward from 2 and tests each one with
// a shared remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive prime_index and raise start while busy is low; the request is
//   taken at that clock edge. busy stays high while the search runs.
//   When the search ends, done is high for exactly one cycle with
//   prime_value, primes_counted and overflow valid in that cycle only;
//   the receiver cannot stall, so it must capture the result then.
//   An index of zero returns zeros; an index above MAX_INDEX returns
//   prime 0, count 0 and overflow 1. Both finish in the cycle after the
//   request. A candidate passing the prime width stops the search with
//   overflow set and the count reached so far.
//   Each candidate is tested with trial divisors from 2 upward until
//   the divisor's square passes the candidate (prime) or a divisor
//   leaves remainder zero (not prime); each trial divisor runs through
//   the remainder unit. One request at a time; a new request may be
//   taken in the cycle done is high.
//   Reset (rst, synchronous) returns the block to idle and drops any
//   search in flight without a result.
// ----------------------------------------------------------------------------
module nth_prime_finder (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  npf_pkg::idx_t prime_index,
  output logic          done,
  output npf_pkg::prime_t prime_value,
  output npf_pkg::idx_t primes_counted,
  output logic          overflow
);
  import npf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CAND = 4'b0010,
    S_TEST = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  target;
  logic [IDX_W-1:0]  count;
  logic [CAND_W-1:0] cand;
  logic [DIV_W-1:0]  trial;
  logic [SQ_W-1:0]   square;
  prime_t            last_prime;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;
  logic              sq_over;

  // Divisor square past the candidate means no divisor left: prime
  assign sq_over = ({{(CAND_W > SQ_W ? CAND_W - SQ_W : 0){1'b0}}, square} > cand);

  // Launch the remainder unit on the current candidate and divisor
  always_comb begin
    rem_req.start    = (state == S_TEST) && !sq_over;
    rem_req.dividend = cand[PRIME_WIDTH-1:0];
    rem_req.divisor  = trial;
  end

  npf_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign busy = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            target     <= prime_index;
            count      <= '0;
            cand       <= CAND_W'(2);
            last_prime <= '0;
            if (prime_index > IDX_W'(MAX_INDEX)) begin
              done           <= 1'b1;
              prime_value    <= '0;
              primes_counted <= '0;
              overflow       <= 1'b1;
            end else if (prime_index == '0) begin
              done           <= 1'b1;
              prime_value    <= '0;
              primes_counted <= '0;
              overflow       <= 1'b0;
            end else begin
              state <= S_CAND;
            end
          end
        end
        S_CAND: begin
          if (count == target) begin
            // Target reached: report the last prime found
            state          <= S_IDLE;
            done           <= 1'b1;
            prime_value    <= last_prime;
            primes_counted <= count;
            overflow       <= 1'b0;
          end else if (cand[CAND_W-1]) begin
            // Candidate left the prime width: stop with overflow
            state          <= S_IDLE;
            done           <= 1'b1;
            prime_value    <= '0;
            primes_counted <= count;
            overflow       <= 1'b1;
          end else begin
            trial  <= DIV_W'(2);
            square <= SQ_W'(4);
            state  <= S_TEST;
          end
        end
        S_TEST: begin
          if (sq_over) begin
            last_prime <= cand[PRIME_WIDTH-1:0];
            count      <= count + 1'b1;
            cand       <= cand + 1'b1;
            state      <= S_CAND;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_rsp.done) begin
            if (rem_rsp.rem_zero) begin
              // Divisor found: drop the candidate
              cand  <= cand + 1'b1;
              state <= S_CAND;
            end else begin
              // Advance divisor; (d+1)^2 = d^2 + 2d + 1
              trial  <= trial + 1'b1;
              square <= square + SQ_W'({trial, 1'b1});
              state  <= S_TEST;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/npf_checker.sv
// ----------------------------------------------------------------------------
// npf_checker: port-level checks for the nth prime finder
// Watches requests and results on the top level and flags bad sequences.
// ----------------------------------------------------------------------------
module npf_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input npf_pkg::idx_t   prime_index,
  input logic            done,
  input npf_pkg::prime_t prime_value,
  input npf_pkg::idx_t   primes_counted,
  input logic            overflow
);
  import npf_pkg::*;

  // A taken request with index zero or out of range finishes at once,
  // any other one starts a search
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=>
      ((($past(prime_index) == '0) || ($past(prime_index) > IDX_W'(MAX_INDEX))) ?
        (done && !busy) : busy))
    else $error("request neither started a search nor finished");

  // Overflow results carry no prime
  a_ovf_no_prime: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (prime_value == '0))
    else $error("overflow result with nonzero prime");

  // A reported prime comes with a nonzero count and is at least two
  a_prime_count: assert property (@(posedge clk) disable iff (rst)
    (done && prime_value != '0) |-> (primes_counted != '0 && prime_value >= PRIME_WIDTH'(2)))
    else $error("prime reported without count");

  // Count never passes the index limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (primes_counted <= IDX_W'(MAX_INDEX)))
    else $error("prime count out of range");

  // A search ends only with a result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without a result");

endmodule

bind nth_prime_finder npf_checker u_npf_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .prime_index    (prime_index),
  .done           (done),
  .prime_value    (prime_value),
  .primes_counted (primes_counted),
  .overflow       (overflow)
);

FILE: tb/sv/nth_prime_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nth_prime_checker: result predictor and scoreboard for nth_prime_finder
// Watches the request and result ports, computes the expected prime, count
// and overflow flag for each accepted request, and compares every result
// strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module nth_prime_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  npf_pkg::idx_t   prime_index,
  input  logic            done,
  input  npf_pkg::prime_t prime_value,
  input  npf_pkg::idx_t   primes_counted,
  input  logic            overflow,
  output int              fail_count,
  output int              outstanding
);
  import npf_pkg::*;

  typedef struct packed {
    prime_t value;
    idx_t   count;
    logic   ovf;
  } prime_answer_t;

  prime_answer_t answers_due[$];
  int            mismatches;

  // Search upward from 2, testing each candidate with divisors up to its root
  function automatic prime_answer_t find_nth_prime(input idx_t n);
    prime_answer_t ans;
    int unsigned   cand;
    int unsigned   found;
    int unsigned   last_prime;
    int unsigned   div;
    int unsigned   cand_limit;
    bit            is_prime;
    ans        = '0;
    found      = 0;
    last_prime = 0;
    cand_limit = (1 << PRIME_WIDTH) - 1;
    if (n > MAX_INDEX) begin
      ans.ovf = 1'b1;
    end else if (n != 0) begin
      cand = 2;
      while (found != n) begin
        // Stop once the candidate would not fit the prime width
        if (cand > cand_limit) begin
          ans.ovf = 1'b1;
          break;
        end
        is_prime = 1'b1;
        for (div = 2; div * div <= cand; div++) begin
          if (cand % div == 0) begin
            is_prime = 1'b0;
            break;
          end
        end
        if (is_prime) begin
          last_prime = cand;
          found++;
        end
        cand++;
      end
      if (!ans.ovf) ans.value = prime_t'(last_prime);
    end
    ans.count = idx_t'(found);
    return ans;
  endfunction

  always @(posedge clk) begin
    prime_answer_t exp_ans;
    if (!rst) begin
      // Check the result strobe against the oldest prediction
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with no request pending: prime %0d count %0d ovf %0b",
                   $time, prime_value, primes_counted, overflow);
          mismatches++;
        end else begin
          exp_ans = answers_due.pop_front();
          if (prime_value !== exp_ans.value) begin
            $display("%0t: prime_value expected %0d actual %0d",
                     $time, exp_ans.value, prime_value);
            mismatches++;
          end
          if (primes_counted !== exp_ans.count) begin
            $display("%0t: primes_counted expected %0d actual %0d",
                     $time, exp_ans.count, primes_counted);
            mismatches++;
          end
          if (overflow !== exp_ans.ovf) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, exp_ans.ovf, overflow);
            mismatches++;
          end
        end
      end
      // Predict the answer for each accepted request
      if (start && !busy) answers_due.push_back(find_nth_prime(prime_index));
    end
    fail_count  <= mismatches;
    outstanding <= answers_due.size();
  end

endmodule

FILE: tb/sv/tb_nth_prime_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nth_prime_finder: top-level testbench for nth_prime_finder
// Drives a directed set of indices (zero, small, overflow boundaries) and
// then random requests under three sender idle profiles; the checker
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_nth_prime_finder;
  import npf_pkg::*;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  idx_t   prime_index = '0;
  logic   done;
  prime_t prime_value;
  idx_t   primes_counted;
  logic   overflow;
  int     fail_count;
  int     outstanding;
  int     sender_idle_pct;

  always #4 clk = ~clk;

  nth_prime_finder u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .prime_index    (prime_index),
    .done           (done),
    .prime_value    (prime_value),
    .primes_counted (primes_counted),
    .overflow       (overflow)
  );

  nth_prime_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .prime_index    (prime_index),
    .done           (done),
    .prime_value    (prime_value),
    .primes_counted (primes_counted),
    .overflow       (overflow),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Idle at random, then present one request and hold it until taken
  task automatic issue_request(input idx_t idx);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    prime_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly small indices keep searches short; some zero and overflow
  function automatic idx_t pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 25) return idx_t'($urandom_range(MAX_INDEX + 1, (1 << IDX_W) - 1));
    if (sel < 88) return idx_t'($urandom_range(1, 24));
    return idx_t'($urandom_range(25, 120));
  endfunction

  idx_t directed_idx[] = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd5, 13'd6, 13'd7,
                           13'd8, 13'd16, 13'd31, 13'd64, 13'd128, 13'd300,
                           13'd4097, 13'd8191, 13'd6826, 13'd5461, 13'd0, 13'd1};

  initial begin
    sender_idle_pct = 38;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Run the directed indices
    foreach (directed_idx[i]) issue_request(directed_idx[i]);

    // Run random requests under three idle profiles
    for (int n = 0; n < 80; n++) begin
      if (n == 27) sender_idle_pct = 71;
      if (n == 54) sender_idle_pct = 0;
      issue_request(pick_index());
    end
    start <= 1'b0;

    // Drain pending results, then allow a short settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
